### design/aqf_pkg.sv
// Shared constants, codes and command types of the alignment quality filter.
`default_nettype none
package aqf_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int OUT_W       = 24;
    localparam int GAP_W       = 24;
    localparam int BASE_W      = 8;
    localparam int MB_W        = 16;
    localparam int MAX_BAD_W   = 10;
    localparam int MIN_BASES_W = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int DIV_STEPS = MB_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_IS_MRNA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERY_TIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BASES  = 2'd3;

    localparam logic                   RST_IS_MRNA    = 1'b1;
    localparam logic                   RST_VERY_TIGHT = 1'b0;
    localparam logic [MAX_BAD_W-1:0]   RST_MAX_BAD    = 10'd100;
    localparam logic [MIN_BASES_W-1:0] RST_MIN_BASES  = 12'd25;

    localparam logic [BASE_W-1:0] BASE_N = 8'h6E;

    localparam logic [COUNT_WIDTH-1:0] VT_MIN_A   = COUNT_WIDTH'(25);
    localparam logic [COUNT_WIDTH-1:0] VT_MIN_B   = COUNT_WIDTH'(15);
    localparam logic [COUNT_WIDTH:0]   VT_SUM_B   = (COUNT_WIDTH + 1)'(50);
    localparam logic [COUNT_WIDTH-1:0] VT_MIN_C   = COUNT_WIDTH'(5);
    localparam logic [COUNT_WIDTH-1:0] VT_REP_C   = COUNT_WIDTH'(100);
    localparam logic [MAX_BAD_W-1:0]   VT_MAX_BAD = 10'd60;
    localparam logic [MAX_BAD_W-1:0]   VT_MAX_C   = 10'd50;

    localparam logic [MB_W-1:0] MB_SAT          = {MB_W{1'b1}};
    localparam logic [MB_W-1:0] ACCEPT_MB_LIMIT = 16'd1024;

    typedef struct packed {
        logic cnt_en;
        logic do_sum;
        logic do_add;
        logic do_mul;
        logic do_check;
        logic do_div;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic sat;
    } t_sts;

endpackage
`default_nettype wire

### design/alignment_quality_filter_unit.sv
// Top level of the alignment quality filter: controller, datapath and checks.
// One aligned base pair is taken per cycle while an alignment is counted.
// After the alignment-end transaction the input stalls through the sum, add, multiply
// and check steps and the 16-step bit-serial divider; a saturated score skips the divider.
// The result sits in an output register and a new alignment may follow at once.
// Synchronous active-low reset clears the counters, loads the register defaults.
`default_nettype none
module alignment_quality_filter_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [aqf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [aqf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  [aqf_pkg::BASE_W-1:0]            i_query_base,
    input  wire  [aqf_pkg::BASE_W-1:0]            i_target_base,
    input  wire                                   i_repeat_flag,
    input  wire                                   i_block_end,
    input  wire  [aqf_pkg::GAP_W-1:0]             i_query_gap,
    input  wire  [aqf_pkg::GAP_W-1:0]             i_target_gap,
    input  wire                                   i_alignment_end,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_accept,
    output logic [aqf_pkg::MB_W-1:0]              o_milli_bad,
    output logic [aqf_pkg::OUT_W-1:0]             o_match_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_mismatch_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_repeat_match_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_unknown_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_query_insert_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_query_insert_bases,
    output logic [aqf_pkg::OUT_W-1:0]             o_target_insert_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_target_insert_bases
);

    aqf_pkg::t_cmd cmd;
    aqf_pkg::t_sts sts;

    aqf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_alignment_end (i_alignment_end),
        .i_out_ready     (i_out_ready),
        .i_sts           (sts),
        .o_in_ready      (o_in_ready),
        .o_out_valid     (o_out_valid),
        .o_cmd           (cmd)
    );

    aqf_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_query_base          (i_query_base),
        .i_target_base         (i_target_base),
        .i_repeat_flag         (i_repeat_flag),
        .i_block_end           (i_block_end),
        .i_query_gap           (i_query_gap),
        .i_target_gap          (i_target_gap),
        .i_alignment_end       (i_alignment_end),
        .o_accept              (o_accept),
        .o_milli_bad           (o_milli_bad),
        .o_match_count         (o_match_count),
        .o_mismatch_count      (o_mismatch_count),
        .o_repeat_match_count  (o_repeat_match_count),
        .o_unknown_count       (o_unknown_count),
        .o_query_insert_count  (o_query_insert_count),
        .o_query_insert_bases  (o_query_insert_bases),
        .o_target_insert_count (o_target_insert_count),
        .o_target_insert_bases (o_target_insert_bases)
    );

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.cnt_en, cmd.do_sum, cmd.do_add, cmd.do_mul,
                  cmd.do_check, cmd.do_div, cmd.load_out}))
        else $error("More than one datapath step commanded in one cycle.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("Result register loaded while a transaction is pending.");

    a_stall_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_alignment_end) |=> !o_in_ready)
        else $error("Input taken while the score is being computed.");

    a_accept_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accept) |-> (o_milli_bad < aqf_pkg::ACCEPT_MB_LIMIT))
        else $error("Accepted alignment with an out-of-range score.");

endmodule
`default_nettype wire

### design/aqf_ctrl.sv
// Controller state machine: counting, scoring sequence and result handshake.
`default_nettype none
module aqf_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_alignment_end,
    input  wire            i_out_ready,
    input  aqf_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output aqf_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_COUNT = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [aqf_pkg::DIV_CNT_W-1:0] DIV_LAST =
        aqf_pkg::DIV_CNT_W'(aqf_pkg::DIV_STEPS - 1);

    logic [2:0]                       r_state, n_state;
    logic [aqf_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic                             r_out_valid, n_out_valid;
    logic                             accept_in;
    logic                             out_free;

    assign o_in_ready  = (r_state == S_COUNT);
    assign o_out_valid = r_out_valid;
    assign accept_in   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_COUNT: begin
                o_cmd.cnt_en = accept_in;
                if (accept_in && i_alignment_end) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.do_check = 1'b1;
                n_cnt          = '0;
                n_state        = i_sts.sat ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.do_div = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_COUNT;
                end
            end
            default: begin
                n_state = S_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COUNT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### design/aqf_dp.sv
// Datapath: configuration, saturating counters, score arithmetic and divider.
`default_nettype none
module aqf_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  aqf_pkg::t_cmd                         i_cmd,
    output aqf_pkg::t_sts                         o_sts,
    input  wire                                   i_cfg_we,
    input  wire  [aqf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [aqf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire  [aqf_pkg::BASE_W-1:0]            i_query_base,
    input  wire  [aqf_pkg::BASE_W-1:0]            i_target_base,
    input  wire                                   i_repeat_flag,
    input  wire                                   i_block_end,
    input  wire  [aqf_pkg::GAP_W-1:0]             i_query_gap,
    input  wire  [aqf_pkg::GAP_W-1:0]             i_target_gap,
    input  wire                                   i_alignment_end,
    output logic                                  o_accept,
    output logic [aqf_pkg::MB_W-1:0]              o_milli_bad,
    output logic [aqf_pkg::OUT_W-1:0]             o_match_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_mismatch_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_repeat_match_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_unknown_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_query_insert_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_query_insert_bases,
    output logic [aqf_pkg::OUT_W-1:0]             o_target_insert_count,
    output logic [aqf_pkg::OUT_W-1:0]             o_target_insert_bases
);

    localparam int CW = aqf_pkg::COUNT_WIDTH;
    localparam int SW = ((CW > aqf_pkg::GAP_W) ? CW : aqf_pkg::GAP_W) + 1;
    localparam int NW = CW + 12;
    localparam int MW = aqf_pkg::MB_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
        return (a == CNT_MAX) ? a : a + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [aqf_pkg::GAP_W-1:0] g);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(g);
        return (s > SW'(CNT_MAX)) ? CNT_MAX : CW'(s);
    endfunction

    logic                              r_is_mrna, r_very_tight;
    logic [aqf_pkg::MAX_BAD_W-1:0]     r_max_bad;
    logic [aqf_pkg::MIN_BASES_W-1:0]   r_min_bases;

    logic [CW-1:0] r_m, r_mm, r_rm, r_unk, r_qi, r_qib, r_ti, r_tib;
    logic [CW-1:0] n_m, n_mm, n_rm, n_unk, n_qi, n_qib, n_ti, n_tib;
    logic [CW-1:0] r_s_m, r_s_mm, r_s_rm, r_s_unk, r_s_qi, r_s_qib, r_s_ti, r_s_tib;

    logic [CW-1:0]   r_dif;
    logic [CW:0]     r_ins;
    logic [CW:0]     r_den;
    logic [CW+1:0]   r_sum;
    logic [NW-1:0]   r_num;
    logic [CW:0]     r_rem;
    logic [MW-1:0]   r_lo;
    logic [MW-1:0]   r_quot;
    logic            r_pa, r_pb, r_pc;

    logic            is_unknown;
    logic [CW+1:0]   trial;
    logic            take;
    logic [aqf_pkg::MAX_BAD_W-1:0] thr1, thr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_mrna    <= aqf_pkg::RST_IS_MRNA;
            r_very_tight <= aqf_pkg::RST_VERY_TIGHT;
            r_max_bad    <= aqf_pkg::RST_MAX_BAD;
            r_min_bases  <= aqf_pkg::RST_MIN_BASES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aqf_pkg::CFG_IS_MRNA:    r_is_mrna    <= i_cfg_data[0];
                aqf_pkg::CFG_VERY_TIGHT: r_very_tight <= i_cfg_data[0];
                aqf_pkg::CFG_MAX_BAD:    r_max_bad    <= i_cfg_data[aqf_pkg::MAX_BAD_W-1:0];
                aqf_pkg::CFG_MIN_BASES:  r_min_bases  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign is_unknown = (i_query_base == aqf_pkg::BASE_N) ||
                        (i_target_base == aqf_pkg::BASE_N);

    always_comb begin
        n_m   = r_m;
        n_mm  = r_mm;
        n_rm  = r_rm;
        n_unk = r_unk;
        n_qi  = r_qi;
        n_qib = r_qib;
        n_ti  = r_ti;
        n_tib = r_tib;
        if (is_unknown) begin
            n_unk = sat_inc(r_unk);
        end else if (i_query_base == i_target_base) begin
            if (i_repeat_flag) begin
                n_rm = sat_inc(r_rm);
            end else begin
                n_m = sat_inc(r_m);
            end
        end else begin
            n_mm = sat_inc(r_mm);
        end
        if (!i_alignment_end && i_block_end) begin
            if (i_query_gap != '0) begin
                n_qi  = sat_inc(r_qi);
                n_qib = sat_add(r_qib, i_query_gap);
            end
            if (i_target_gap != '0) begin
                n_ti  = sat_inc(r_ti);
                n_tib = sat_add(r_tib, i_target_gap);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m   <= '0;
            r_mm  <= '0;
            r_rm  <= '0;
            r_unk <= '0;
            r_qi  <= '0;
            r_qib <= '0;
            r_ti  <= '0;
            r_tib <= '0;
        end else if (i_cmd.cnt_en) begin
            if (i_alignment_end) begin
                r_m   <= '0;
                r_mm  <= '0;
                r_rm  <= '0;
                r_unk <= '0;
                r_qi  <= '0;
                r_qib <= '0;
                r_ti  <= '0;
                r_tib <= '0;
            end else begin
                r_m   <= n_m;
                r_mm  <= n_mm;
                r_rm  <= n_rm;
                r_unk <= n_unk;
                r_qi  <= n_qi;
                r_qib <= n_qib;
                r_ti  <= n_ti;
                r_tib <= n_tib;
            end
        end
    end

    // The query and target spans share the aligned length, so their
    // difference is the difference of the insert bases.
    assign trial = {r_rem, r_lo[MW-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_en && i_alignment_end) begin
            r_s_m   <= n_m;
            r_s_mm  <= n_mm;
            r_s_rm  <= n_rm;
            r_s_unk <= n_unk;
            r_s_qi  <= r_qi;
            r_s_qib <= r_qib;
            r_s_ti  <= r_ti;
            r_s_tib <= r_tib;
        end
        if (i_cmd.do_sum) begin
            if (r_s_qib >= r_s_tib) begin
                r_dif <= r_s_qib - r_s_tib;
            end else begin
                r_dif <= r_is_mrna ? '0 : (r_s_tib - r_s_qib);
            end
            r_ins <= {1'b0, r_s_qi} + (r_is_mrna ? '0 : {1'b0, r_s_ti});
            r_den <= {1'b0, r_s_m} + {1'b0, r_s_rm};
        end
        if (i_cmd.do_add) begin
            r_sum <= (CW + 2)'(r_s_mm) + (CW + 2)'(r_ins) + (CW + 2)'(r_dif);
            if (r_very_tight) begin
                r_pa <= r_s_m >= aqf_pkg::VT_MIN_A;
                r_pb <= (r_s_m >= aqf_pkg::VT_MIN_B) && (r_den >= aqf_pkg::VT_SUM_B);
                r_pc <= (r_s_m >= aqf_pkg::VT_MIN_C) && (r_s_rm >= aqf_pkg::VT_REP_C);
            end else begin
                r_pa <= r_s_m >= CW'(r_min_bases);
                r_pb <= (r_s_m >= CW'(r_min_bases >> 1)) &&
                        (r_den >= (CW + 1)'({r_min_bases, 1'b0}));
                r_pc <= r_s_rm >= CW'({r_min_bases, 2'b00});
            end
        end
        if (i_cmd.do_mul) begin
            r_num <= {r_sum, 10'b0} - NW'({r_sum, 5'b0}) + NW'({r_sum, 3'b0});
        end
        if (i_cmd.do_check) begin
            r_rem  <= (CW + 1)'(r_num[NW-1:MW]);
            r_lo   <= r_num[MW-1:0];
            r_quot <= o_sts.sat ? aqf_pkg::MB_SAT : '0;
        end
        if (i_cmd.do_div) begin
            r_rem  <= take ? (CW + 1)'(trial - {1'b0, r_den}) : trial[CW:0];
            r_lo   <= {r_lo[MW-2:0], 1'b0};
            r_quot <= {r_quot[MW-2:0], take};
        end
        if (i_cmd.load_out) begin
            o_accept              <= (r_den != '0) && (r_quot < MW'(thr1)) &&
                                     (r_pa || r_pb || (r_pc && (r_quot < MW'(thr2))));
            o_milli_bad           <= r_quot;
            o_match_count         <= aqf_pkg::OUT_W'(r_s_m);
            o_mismatch_count      <= aqf_pkg::OUT_W'(r_s_mm);
            o_repeat_match_count  <= aqf_pkg::OUT_W'(r_s_rm);
            o_unknown_count       <= aqf_pkg::OUT_W'(r_s_unk);
            o_query_insert_count  <= aqf_pkg::OUT_W'(r_s_qi);
            o_query_insert_bases  <= aqf_pkg::OUT_W'(r_s_qib);
            o_target_insert_count <= aqf_pkg::OUT_W'(r_s_ti);
            o_target_insert_bases <= aqf_pkg::OUT_W'(r_s_tib);
        end
    end

    assign thr1 = r_very_tight ? aqf_pkg::VT_MAX_BAD : r_max_bad;
    assign thr2 = r_very_tight ? aqf_pkg::VT_MAX_C : (r_max_bad >> 1);

    assign o_sts.sat = (r_den == '0) ||
                       ((CW + 1 + MW)'(r_num) >= {r_den, {MW{1'b0}}});

endmodule
`default_nettype wire

### dv/alignment_score_checker.sv
// Checker that predicts alignment quality reports and compares them with the block's output.
module alignment_score_checker
    import aqf_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  wire [BASE_W-1:0]      i_query_base,
    input  wire [BASE_W-1:0]      i_target_base,
    input  wire                   i_repeat_flag,
    input  wire                   i_block_end,
    input  wire [GAP_W-1:0]       i_query_gap,
    input  wire [GAP_W-1:0]       i_target_gap,
    input  wire                   i_alignment_end,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  wire                   i_accept,
    input  wire [MB_W-1:0]        i_milli_bad,
    input  wire [OUT_W-1:0]       i_match_count,
    input  wire [OUT_W-1:0]       i_mismatch_count,
    input  wire [OUT_W-1:0]       i_repeat_match_count,
    input  wire [OUT_W-1:0]       i_unknown_count,
    input  wire [OUT_W-1:0]       i_query_insert_count,
    input  wire [OUT_W-1:0]       i_query_insert_bases,
    input  wire [OUT_W-1:0]       i_target_insert_count,
    input  wire [OUT_W-1:0]       i_target_insert_bases,
    output int                    o_errors,
    output int                    o_pending
);

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam longint unsigned MILLI_SAT = 64'd65535;
    localparam longint unsigned PER_MILLE = 64'd1000;
    localparam logic [BASE_W-1:0] LOWER_N = "n";

    localparam longint unsigned TIGHT_MAX_BAD     = 60;
    localparam longint unsigned TIGHT_MAX_BAD_REP = 50;
    localparam longint unsigned TIGHT_MIN_UNIQUE  = 25;
    localparam longint unsigned TIGHT_MIN_MIXED   = 15;
    localparam longint unsigned TIGHT_SUM_MIXED   = 50;
    localparam longint unsigned TIGHT_MIN_REP     = 5;
    localparam longint unsigned TIGHT_REP_REP     = 100;

    typedef struct packed {
        logic             accept;
        logic [MB_W-1:0]  milli_bad;
        logic [OUT_W-1:0] match_cnt;
        logic [OUT_W-1:0] mismatches;
        logic [OUT_W-1:0] repeat_matches;
        logic [OUT_W-1:0] unknowns;
        logic [OUT_W-1:0] q_inserts;
        logic [OUT_W-1:0] q_insert_bases;
        logic [OUT_W-1:0] t_inserts;
        logic [OUT_W-1:0] t_insert_bases;
    } t_report;

    t_report expected_reports[$];
    int      err_count = 0;

    logic                   cfg_is_mrna;
    logic                   cfg_very_tight;
    logic [MAX_BAD_W-1:0]   cfg_max_bad;
    logic [MIN_BASES_W-1:0] cfg_min_bases;

    logic [COUNT_WIDTH-1:0] cnt_match, cnt_mismatch, cnt_repeat, cnt_unknown;
    logic [COUNT_WIDTH-1:0] cnt_q_ins, cnt_q_bases, cnt_t_ins, cnt_t_bases;

    function automatic logic [COUNT_WIDTH-1:0] add_clamped(logic [COUNT_WIDTH-1:0] a,
                                                           longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX) : COUNT_WIDTH'(s);
    endfunction

    task automatic clear_counts();
        cnt_match = '0;
        cnt_mismatch = '0;
        cnt_repeat = '0;
        cnt_unknown = '0;
        cnt_q_ins = '0;
        cnt_q_bases = '0;
        cnt_t_ins = '0;
        cnt_t_bases = '0;
    endtask

    function automatic t_report close_alignment();
        longint unsigned m, r, aligned, qspan, tspan, dif, ins, den, mb, lim, need;
        logic ok;
        t_report rpt;
        m = cnt_match;
        r = cnt_repeat;
        aligned = m + r + 64'(cnt_mismatch) + 64'(cnt_unknown);
        qspan = aligned + 64'(cnt_q_bases);
        tspan = aligned + 64'(cnt_t_bases);
        if (qspan >= tspan) begin
            dif = qspan - tspan;
        end else if (cfg_is_mrna) begin
            dif = 0;
        end else begin
            dif = tspan - qspan;
        end
        ins = cnt_q_ins;
        if (!cfg_is_mrna) begin
            ins = ins + 64'(cnt_t_ins);
        end
        den = m + r;
        if (den == 0) begin
            mb = MILLI_SAT;
        end else begin
            mb = (PER_MILLE * (64'(cnt_mismatch) + ins + dif)) / den;
            if (mb > MILLI_SAT) begin
                mb = MILLI_SAT;
            end
        end
        lim = cfg_max_bad;
        need = cfg_min_bases;
        if (den == 0) begin
            ok = 1'b0;
        end else if (cfg_very_tight) begin
            ok = (mb < TIGHT_MAX_BAD) &&
                 (m >= TIGHT_MIN_UNIQUE ||
                  (m >= TIGHT_MIN_MIXED && m + r >= TIGHT_SUM_MIXED) ||
                  (m >= TIGHT_MIN_REP && r >= TIGHT_REP_REP && mb < TIGHT_MAX_BAD_REP));
        end else begin
            ok = (mb < lim) &&
                 (m >= need ||
                  (m >= need / 2 && m + r >= 2 * need) ||
                  (r >= 4 * need && mb < lim / 2));
        end
        rpt.accept = ok;
        rpt.milli_bad = MB_W'(mb);
        rpt.match_cnt = OUT_W'(cnt_match);
        rpt.mismatches = OUT_W'(cnt_mismatch);
        rpt.repeat_matches = OUT_W'(cnt_repeat);
        rpt.unknowns = OUT_W'(cnt_unknown);
        rpt.q_inserts = OUT_W'(cnt_q_ins);
        rpt.q_insert_bases = OUT_W'(cnt_q_bases);
        rpt.t_inserts = OUT_W'(cnt_t_ins);
        rpt.t_insert_bases = OUT_W'(cnt_t_bases);
        return rpt;
    endfunction

    task automatic absorb_base();
        if (i_query_base == LOWER_N || i_target_base == LOWER_N) begin
            cnt_unknown = add_clamped(cnt_unknown, 1);
        end else if (i_query_base == i_target_base) begin
            if (i_repeat_flag) begin
                cnt_repeat = add_clamped(cnt_repeat, 1);
            end else begin
                cnt_match = add_clamped(cnt_match, 1);
            end
        end else begin
            cnt_mismatch = add_clamped(cnt_mismatch, 1);
        end
        if (i_alignment_end) begin
            expected_reports.push_back(close_alignment());
            clear_counts();
        end else if (i_block_end) begin
            if (i_query_gap != '0) begin
                cnt_q_ins = add_clamped(cnt_q_ins, 1);
                cnt_q_bases = add_clamped(cnt_q_bases, i_query_gap);
            end
            if (i_target_gap != '0) begin
                cnt_t_ins = add_clamped(cnt_t_ins, 1);
                cnt_t_bases = add_clamped(cnt_t_bases, i_target_gap);
            end
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_report want;
        if (!i_rst_n) begin
            clear_counts();
            cfg_is_mrna = RST_IS_MRNA;
            cfg_very_tight = RST_VERY_TIGHT;
            cfg_max_bad = RST_MAX_BAD;
            cfg_min_bases = RST_MIN_BASES;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IS_MRNA:    cfg_is_mrna = i_cfg_data[0];
                    CFG_VERY_TIGHT: cfg_very_tight = i_cfg_data[0];
                    CFG_MAX_BAD:    cfg_max_bad = i_cfg_data[MAX_BAD_W-1:0];
                    CFG_MIN_BASES:  cfg_min_bases = i_cfg_data[MIN_BASES_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report transaction with none expected, expected none, actual milli_bad %0d",
                             $time, i_milli_bad);
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("accept", want.accept, i_accept);
                    check_field("milli_bad", want.milli_bad, i_milli_bad);
                    check_field("match_count", want.match_cnt, i_match_count);
                    check_field("mismatch_count", want.mismatches, i_mismatch_count);
                    check_field("repeat_match_count", want.repeat_matches,
                                i_repeat_match_count);
                    check_field("unknown_count", want.unknowns, i_unknown_count);
                    check_field("query_insert_count", want.q_inserts, i_query_insert_count);
                    check_field("query_insert_bases", want.q_insert_bases,
                                i_query_insert_bases);
                    check_field("target_insert_count", want.t_inserts, i_target_insert_count);
                    check_field("target_insert_bases", want.t_insert_bases,
                                i_target_insert_bases);
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_base();
            end
        end
        o_errors <= err_count;
        o_pending <= expected_reports.size();
    end

endmodule

### dv/testbench.sv
// Testbench top that streams alignments into the quality filter and reports the verdict.
module testbench;
    import aqf_pkg::*;

    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 260;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [BASE_W-1:0]     query_base = '0;
    logic [BASE_W-1:0]     target_base = '0;
    logic                  repeat_flag = 1'b0;
    logic                  block_end = 1'b0;
    logic [GAP_W-1:0]      query_gap = '0;
    logic [GAP_W-1:0]      target_gap = '0;
    logic                  alignment_end = 1'b0;
    logic                  out_ready = 1'b0;

    wire                   in_ready;
    wire                   out_valid;
    wire                   accept;
    wire [MB_W-1:0]        milli_bad;
    wire [OUT_W-1:0]       match_count, mismatch_count, repeat_match_count, unknown_count;
    wire [OUT_W-1:0]       query_insert_count, query_insert_bases;
    wire [OUT_W-1:0]       target_insert_count, target_insert_bases;

    int errors;
    int pending;
    int items_sent = 0;
    int in_idle_pct = 0;
    bit out_stalls = 1'b0;
    int ready_hold = 0;
    int idle_cycles = 0;

    localparam logic [31:0] LOWER_ACGT = "acgt";
    localparam logic [31:0] UPPER_ACGT = "ACGT";

    alignment_quality_filter_unit uut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_idx             (cfg_idx),
        .i_cfg_data            (cfg_data),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_query_base          (query_base),
        .i_target_base         (target_base),
        .i_repeat_flag         (repeat_flag),
        .i_block_end           (block_end),
        .i_query_gap           (query_gap),
        .i_target_gap          (target_gap),
        .i_alignment_end       (alignment_end),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_accept              (accept),
        .o_milli_bad           (milli_bad),
        .o_match_count         (match_count),
        .o_mismatch_count      (mismatch_count),
        .o_repeat_match_count  (repeat_match_count),
        .o_unknown_count       (unknown_count),
        .o_query_insert_count  (query_insert_count),
        .o_query_insert_bases  (query_insert_bases),
        .o_target_insert_count (target_insert_count),
        .o_target_insert_bases (target_insert_bases)
    );

    alignment_score_checker u_score_check (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_idx             (cfg_idx),
        .i_cfg_data            (cfg_data),
        .i_in_valid            (in_valid),
        .i_in_ready            (in_ready),
        .i_query_base          (query_base),
        .i_target_base         (target_base),
        .i_repeat_flag         (repeat_flag),
        .i_block_end           (block_end),
        .i_query_gap           (query_gap),
        .i_target_gap          (target_gap),
        .i_alignment_end       (alignment_end),
        .i_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .i_accept              (accept),
        .i_milli_bad           (milli_bad),
        .i_match_count         (match_count),
        .i_mismatch_count      (mismatch_count),
        .i_repeat_match_count  (repeat_match_count),
        .i_unknown_count       (unknown_count),
        .i_query_insert_count  (query_insert_count),
        .i_query_insert_bases  (query_insert_bases),
        .i_target_insert_count (target_insert_count),
        .i_target_insert_bases (target_insert_bases),
        .o_errors              (errors),
        .o_pending             (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            out_ready <= 1'b0;
        end else if (out_stalls && $urandom_range(0, 7) == 0) begin
            ready_hold <= int'($urandom_range(0, 13));
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [BASE_W-1:0] random_base();
        int roll;
        int k;
        roll = int'($urandom_range(0, 99));
        k = int'($urandom_range(0, 3));
        if (roll < 78) begin
            return LOWER_ACGT[8*k +: 8];
        end else if (roll < 88) begin
            return UPPER_ACGT[8*k +: 8];
        end else if (roll < 93) begin
            return "n";
        end else if (roll < 96) begin
            return "N";
        end
        return BASE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [GAP_W-1:0] random_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 30) begin
            return '0;
        end else if (roll < 85) begin
            return GAP_W'($urandom_range(1, 30));
        end else if (roll < 95) begin
            return GAP_W'($urandom);
        end
        return '1;
    endfunction

    task automatic drive_base(input logic [BASE_W-1:0] qb, input logic [BASE_W-1:0] tb,
                              input logic rep, input logic bend, input logic [GAP_W-1:0] qg,
                              input logic [GAP_W-1:0] tg, input logic aend);
        int gap;
        gap = 0;
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            gap = int'($urandom_range(1, 14));
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        query_base <= qb;
        target_base <= tb;
        repeat_flag <= rep;
        block_end <= bend;
        query_gap <= qg;
        target_gap <= tg;
        alignment_end <= aend;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_alignment(input int len, input int err_pct, input int rep_pct);
        logic [BASE_W-1:0] qb, tb;
        logic [GAP_W-1:0]  qg, tg;
        logic              rep, bend;
        for (int i = 0; i < len; i++) begin
            qb = random_base();
            tb = ($urandom_range(0, 99) < err_pct) ? random_base() : qb;
            rep = ($urandom_range(0, 99) < rep_pct);
            bend = ($urandom_range(0, 7) == 0);
            if (bend && i != len - 1) begin
                qg = random_gap();
                tg = random_gap();
            end else begin
                qg = GAP_W'($urandom);
                tg = GAP_W'($urandom);
            end
            drive_base(qb, tb, rep, bend, qg, tg, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic mrna, input logic tight,
                                input logic [MAX_BAD_W-1:0] max_bad,
                                input logic [MIN_BASES_W-1:0] min_bases);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_IS_MRNA;
        cfg_data <= CFG_DATA_W'(mrna);
        @(posedge clk);
        cfg_idx <= CFG_VERY_TIGHT;
        cfg_data <= CFG_DATA_W'(tight);
        @(posedge clk);
        cfg_idx <= CFG_MAX_BAD;
        cfg_data <= CFG_DATA_W'(max_bad);
        @(posedge clk);
        cfg_idx <= CFG_MIN_BASES;
        cfg_data <= CFG_DATA_W'(min_bases);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int phase_start;
        int len;
        int roll;
        int err_pct;
        int rep_pct;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            out_stalls = (phase != NUM_PHASES - 1) && (phase % 3 != 2);
            in_idle_pct = (phase == NUM_PHASES - 1 || phase % 3 == 1) ? 0 : 20;
            phase_start = items_sent;
            if (phase == 0) begin
                // Alignments without any matched base, uppercase N, ignored gaps and saturation.
                drive_base("n", "a", 1'b0, 1'b0, '0, '0, 1'b1);
                drive_base("N", "N", 1'b0, 1'b1, 24'd5, 24'd7, 1'b0);
                drive_base("a", "n", 1'b1, 1'b0, 24'hABCDEF, 24'h123456, 1'b0);
                drive_base("g", "g", 1'b1, 1'b1, '0, '0, 1'b0);
                drive_base("c", "t", 1'b0, 1'b1, '1, '1, 1'b1);
                drive_base("a", "a", 1'b0, 1'b1, '1, '1, 1'b0);
                drive_base("a", "a", 1'b0, 1'b1, '1, 24'd0, 1'b0);
                drive_base("c", "c", 1'b1, 1'b0, '0, '0, 1'b1);
                drive_base(8'h00, 8'h00, 1'b0, 1'b0, '0, '0, 1'b0);
                drive_base(8'hFF, 8'hFF, 1'b1, 1'b0, '1, '1, 1'b0);
                drive_base(8'h00, 8'hFF, 1'b0, 1'b1, 24'd1, 24'd0, 1'b0);
                drive_base(8'hFF, 8'h00, 1'b0, 1'b1, 24'd0, 24'h800000, 1'b0);
                drive_base("t", "t", 1'b0, 1'b0, '0, '0, 1'b1);
                drive_base("g", "g", 1'b1, 1'b0, '0, '0, 1'b1);
            end else begin
                wait_drained();
                case (phase)
                    1: apply_config(1'b0, 1'b0, 10'd1000, 12'd0);
                    2: apply_config(1'b1, 1'b0, 10'd0, 12'd4095);
                    3: apply_config(1'b1, 1'b1, 10'($urandom_range(0, 1000)),
                                    12'($urandom_range(0, 4095)));
                    4: apply_config(1'b0, 1'b1, 10'($urandom_range(0, 1000)),
                                    12'($urandom_range(0, 4095)));
                    5: apply_config(1'b0, 1'b0, 10'($urandom_range(50, 400)),
                                    12'($urandom_range(0, 60)));
                    default: apply_config(1'b1, 1'b0, 10'd100, 12'd25);
                endcase
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                roll = int'($urandom_range(0, 99));
                if (roll < 20) begin
                    len = int'($urandom_range(1, 4));
                end else if (roll < 85) begin
                    len = int'($urandom_range(5, 45));
                end else if (roll < 97) begin
                    len = int'($urandom_range(46, 130));
                end else begin
                    len = int'($urandom_range(131, 220));
                end
                case ($urandom_range(0, 5))
                    0: err_pct = 0;
                    1: err_pct = 1;
                    2: err_pct = 3;
                    3: err_pct = 8;
                    4: err_pct = 25;
                    default: err_pct = 100;
                endcase
                case ($urandom_range(0, 3))
                    0: rep_pct = 0;
                    1: rep_pct = 10;
                    2: rep_pct = 50;
                    default: rep_pct = 95;
                endcase
                send_alignment(len, err_pct, rep_pct);
            end
        end
        wait_drained();
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
